>>> design/modular_exponentiation_top_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef MODULAR_EXPONENTIATION_TOP_ASSERT_SVH
`define MODULAR_EXPONENTIATION_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MEXP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define MEXP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/modexp_pkg.sv
`default_nettype none
package modexp_pkg;

  localparam int unsigned FieldW   = 63;
  localparam int unsigned ModW     = 31;
  localparam int unsigned AccW     = 32;
  localparam int unsigned CntW     = 6;
  localparam int unsigned ExpBitsDefault = 63;
  localparam logic [ModW-1:0] ModulusReset = 31'd1000000007;

  typedef enum logic [2:0] {
    StIdle,
    StReduce,
    StCheck,
    StMulAcc,
    StSqInit,
    StMulSq,
    StDone
  } state_e;

  typedef struct packed {
    logic load;
    logic red_step;
    logic red_end;
    logic mul_init;
    logic mul_sel_acc;
    logic mul_step;
    logic wb_acc;
    logic wb_pw;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic e_zero;
    logic e_lsb;
    logic mod_small;
  } status_t;

endpackage
`default_nettype wire

>>> design/modexp_ctrl.sv
`default_nettype none
module modexp_ctrl
  import modexp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start_i,
  input  wire status_t status_i,
  output cmd_t         cmd_o,
  output logic         busy_o,
  output logic         done_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:   if (start_i) state_d = StReduce;
      StReduce: if (status_i.cnt_zero) state_d = StCheck;
      StCheck: begin
        if (status_i.e_zero || status_i.mod_small) begin
          state_d = StDone;
        end else if (status_i.e_lsb) begin
          state_d = StMulAcc;
        end else begin
          state_d = StMulSq;
        end
      end
      StMulAcc: if (status_i.cnt_zero) state_d = StSqInit;
      StSqInit: state_d = StMulSq;
      StMulSq:  if (status_i.cnt_zero) state_d = StCheck;
      StDone:   state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    done_o = 1'b0;
    case (state_q)
      StIdle: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      StReduce: begin
        cmd_o.red_step = 1'b1;
        cmd_o.red_end  = status_i.cnt_zero;
      end
      StCheck: begin
        if (!(status_i.e_zero || status_i.mod_small)) begin
          cmd_o.mul_init    = 1'b1;
          cmd_o.mul_sel_acc = status_i.e_lsb;
        end
      end
      StMulAcc: begin
        cmd_o.mul_step = 1'b1;
        cmd_o.wb_acc   = status_i.cnt_zero;
      end
      StSqInit: cmd_o.mul_init = 1'b1;
      StMulSq: begin
        cmd_o.mul_step = 1'b1;
        cmd_o.wb_pw    = status_i.cnt_zero;
      end
      StDone:  done_o = 1'b1;
      default: busy_o = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

>>> design/modexp_dp.sv
`default_nettype none
module modexp_dp
  import modexp_pkg::*;
#(
  parameter int unsigned EXPONENT_BITS = ExpBitsDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              modulus_we_i,
  input  wire logic [ModW-1:0]   modulus_wdata_i,
  input  wire logic [FieldW-1:0] base_i,
  input  wire logic [FieldW-1:0] exponent_i,
  input  wire cmd_t              cmd_i,
  output status_t                status_o,
  output logic      [ModW-1:0]   power_mod_o
);

  localparam logic [63:0] ExpMask = (64'd1 << EXPONENT_BITS) - 64'd1;

  logic [ModW-1:0]   mod_q;
  logic [FieldW-1:0] x_q, x_d;
  logic [FieldW-1:0] e_q, e_d;
  logic [ModW-1:0]   acc_q, acc_d, pw_q, pw_d, ma_q, ma_d, mb_q, mb_d, r_q, r_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [AccW-1:0]   m_w, red_t, red_r, dbl_t, dbl_r, add_t, add_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= ModulusReset;
    end else if (modulus_we_i) begin
      mod_q <= modulus_wdata_i;
    end
  end

  // One remainder bit per cycle for the base; one multiplier bit per cycle
  // for the products, with at most two conditional subtractions.
  always_comb begin
    m_w   = {1'b0, mod_q};
    red_t = {r_q, x_q[FieldW-1]};
    red_r = (red_t >= m_w) ? red_t - m_w : red_t;
    dbl_t = {r_q, 1'b0};
    dbl_r = (dbl_t >= m_w) ? dbl_t - m_w : dbl_t;
    add_t = dbl_r + (mb_q[ModW-1] ? {1'b0, ma_q} : '0);
    add_r = (add_t >= m_w) ? add_t - m_w : add_t;
  end

  always_comb begin
    x_d = x_q; e_d = e_q; acc_d = acc_q; pw_d = pw_q;
    ma_d = ma_q; mb_d = mb_q; r_d = r_q; cnt_d = cnt_q;
    if (cmd_i.load) begin
      x_d   = base_i;
      e_d   = exponent_i & ExpMask[FieldW-1:0];
      acc_d = ModW'(1);
      r_d   = '0;
      cnt_d = CntW'(FieldW - 1);
    end
    if (cmd_i.red_step) begin
      r_d   = red_r[ModW-1:0];
      x_d   = {x_q[FieldW-2:0], 1'b0};
      cnt_d = cnt_q - CntW'(1);
    end
    if (cmd_i.red_end) pw_d = red_r[ModW-1:0];
    if (cmd_i.mul_init) begin
      ma_d  = cmd_i.mul_sel_acc ? acc_q : pw_q;
      mb_d  = pw_q;
      r_d   = '0;
      cnt_d = CntW'(ModW - 1);
    end
    if (cmd_i.mul_step) begin
      r_d   = add_r[ModW-1:0];
      mb_d  = {mb_q[ModW-2:0], 1'b0};
      cnt_d = cnt_q - CntW'(1);
    end
    if (cmd_i.wb_acc) acc_d = add_r[ModW-1:0];
    if (cmd_i.wb_pw) begin
      pw_d = add_r[ModW-1:0];
      e_d  = {1'b0, e_q[FieldW-1:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; e_q <= e_d; acc_q <= acc_d; pw_q <= pw_d;
    ma_q <= ma_d; mb_q <= mb_d; r_q <= r_d; cnt_q <= cnt_d;
  end

  assign status_o.cnt_zero  = (cnt_q == '0);
  assign status_o.e_zero    = (e_q == '0);
  assign status_o.e_lsb     = e_q[0];
  assign status_o.mod_small = (mod_q < ModW'(2));
  assign power_mod_o        = status_o.mod_small ? '0 : acc_q;

endmodule
`default_nettype wire

>>> design/modular_exponentiation_top.sv
// The run time grows with the exponent: every scanned exponent bit up to the
// highest set one costs one squaring, and every set bit one more multiply.
// One item at a time; busy stays high through the result strobe.
// The cost is set by the shared bit-serial modular multiplier (one bit a cycle).
// Reset clears the controller and sets the modulus to 1000000007; the
// receiver cannot stall, the result is shown for exactly one cycle.
`default_nettype none
module modular_exponentiation_top
  import modexp_pkg::*;
#(
  parameter int unsigned EXPONENT_BITS = ExpBitsDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              modulus_we_i,
  input  wire logic [ModW-1:0]   modulus_wdata_i,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [FieldW-1:0] base_i,
  input  wire logic [FieldW-1:0] exponent_i,
  output logic                   done_o,
  output logic      [ModW-1:0]   power_mod_o
);

  // The controller sequences the base reduction, then walks the exponent
  // from its least significant bit. Each set bit costs one modular multiply
  // into the accumulator; every bit costs one squaring of the power.
  cmd_t    cmd;
  status_t status;

  modexp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  // The datapath holds the modulus register and all operand registers. A
  // transfer on the input side loads base and exponent; the accumulator, or
  // zero for a modulus below two, is on the output while done is high.
  modexp_dp #(
    .EXPONENT_BITS (EXPONENT_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .modulus_we_i    (modulus_we_i),
    .modulus_wdata_i (modulus_wdata_i),
    .base_i          (base_i),
    .exponent_i      (exponent_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .power_mod_o     (power_mod_o)
  );

endmodule
`default_nettype wire

>>> design/modexp_chk.sv
`default_nettype none
`include "modular_exponentiation_top_assert.svh"
module modexp_chk (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic done_o
);

  `MEXP_ASSERT_IMP(a_done_busy, clk_i, rst_ni, done_o, busy)
  `MEXP_ASSERT_NXT(a_done_idle, clk_i, rst_ni, done_o, !busy && !done_o)
  `MEXP_ASSERT_NXT(a_start_busy, clk_i, rst_ni, start && !busy, busy && !done_o)
  `MEXP_ASSERT_IMP(a_idle_nodone, clk_i, rst_ni, !busy, !done_o)

endmodule

bind modular_exponentiation_top modexp_chk u_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o)
);
`default_nettype wire

>>> verif/modular_exponentiation_checker.sv
`default_nettype none
module modular_exponentiation_checker
  import modexp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              modulus_we_i,
  input  wire logic [ModW-1:0]   modulus_wdata_i,
  input  wire logic              start_i,
  input  wire logic              busy_i,
  input  wire logic [FieldW-1:0] base_i,
  input  wire logic [FieldW-1:0] exponent_i,
  input  wire logic              done_i,
  input  wire logic [ModW-1:0]   power_mod_i,
  output int                     fail_count_o,
  output int                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [ModW-1:0] modulus_q;
  logic [ModW-1:0] expected_powers[$];

  // Right-to-left square-and-multiply; a modulus below two yields zero.
  function automatic logic [ModW-1:0] power_mod_of(logic [FieldW-1:0] b,
                                                  logic [FieldW-1:0] e,
                                                  logic [ModW-1:0] m);
    logic [63:0]       mm;
    logic [63:0]       pw;
    logic [63:0]       acc;
    logic [FieldW-1:0] rest;
    if (m < 2) return '0;
    mm   = 64'(m);
    pw   = 64'(b) % mm;
    acc  = 64'd1;
    rest = e;
    while (rest != '0) begin
      if (rest[0]) acc = (acc * pw) % mm;
      pw   = (pw * pw) % mm;
      rest = rest >> 1;
    end
    return acc[ModW-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [ModW-1:0] want;
    if (!rst_ni) begin
      modulus_q = ModulusReset;
      expected_powers.delete();
      fail_count_o = 0;
    end else begin
      if (done_i) begin
        if (expected_powers.size() == 0) begin
          $error("unexpected result power_mod=%0d", power_mod_i);
          fail_count_o++;
        end else begin
          want = expected_powers.pop_front();
          if (power_mod_i !== want) begin
            $error("power_mod mismatch: expected %0d actual %0d", want, power_mod_i);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i)
        expected_powers = {expected_powers, power_mod_of(base_i, exponent_i, modulus_q)};
      if (modulus_we_i) modulus_q = modulus_wdata_i;
    end
    pending_o = expected_powers.size();
  end
endmodule
`default_nettype wire

>>> verif/testbench.sv
`default_nettype none
module testbench
  import modexp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // The block is slow for wide exponents, so the limit is taken from the
  // worst-case item time plus sender gaps, several times over.
  localparam longint CycleLimit = 30_000_000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              modulus_we_i = 1'b0;
  logic [ModW-1:0]   modulus_wdata_i = '0;
  logic              start = 1'b0;
  logic              busy;
  logic [FieldW-1:0] base_i = '0;
  logic [FieldW-1:0] exponent_i = '0;
  logic              done_o;
  logic [ModW-1:0]   power_mod_o;
  int                fail_count;
  int                pending;
  longint            cycle_count = 0;
  logic [ModW-1:0]   modulus_now = ModulusReset;
  int                sender_idle_pct = 0;

  always #1 clk_i = ~clk_i;

  modular_exponentiation_top dut (
    .clk_i, .rst_ni, .modulus_we_i, .modulus_wdata_i, .start, .busy,
    .base_i, .exponent_i, .done_o, .power_mod_o
  );

  modular_exponentiation_checker checker_i (
    .clk_i, .rst_ni, .modulus_we_i, .modulus_wdata_i,
    .start_i(start), .busy_i(busy), .base_i, .exponent_i,
    .done_i(done_o), .power_mod_i(power_mod_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // A stuck block must not hang the run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Offers one item and holds it until the block takes the transfer. The item
  // is taken at a rising edge where busy, sampled before that edge, is low.
  task automatic send_power(logic [FieldW-1:0] b, logic [FieldW-1:0] e);
    bit taken;
    @(negedge clk_i);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(8, 1)) @(negedge clk_i);
    end
    start      <= 1'b1;
    base_i     <= b;
    exponent_i <= e;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !busy;
    end
  endtask

  // Drains the block, lets the controller settle, then writes the modulus.
  task automatic write_modulus(logic [ModW-1:0] value);
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    modulus_we_i    <= 1'b1;
    modulus_wdata_i <= value;
    @(negedge clk_i);
    modulus_we_i    <= 1'b0;
    modulus_now = value;
  endtask

  // Most exponents are short so the run stays fast; a few use all 63 bits
  // so that every exponent bit is exercised.
  function automatic logic [FieldW-1:0] pick_exponent();
    logic [FieldW-1:0] e;
    e = FieldW'({$urandom, $urandom});
    if ($urandom_range(15) != 0)
      e = e & ((FieldW'(1) << $urandom_range(12)) - FieldW'(1));
    return e;
  endfunction

  function automatic logic [FieldW-1:0] pick_base();
    logic [FieldW-1:0] b;
    case ($urandom_range(3))
      0: b = FieldW'($urandom_range(3));
      1: b = FieldW'(modulus_now) * FieldW'($urandom) + FieldW'($urandom_range(1));
      default: b = FieldW'({$urandom, $urandom});
    endcase
    return b;
  endfunction

  initial begin
    logic [ModW-1:0] moduli[7];
    logic [FieldW-1:0] all_ones;
    all_ones = '1;
    moduli = '{31'd2, 31'h7FFF_FFFF, 31'd0, 31'd1, 31'd1000000007, 31'd3, 31'd65537};
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed items under the reset modulus: field extremes, a zero exponent,
    // and bases that reduce to zero or to the modulus minus one.
    send_power('0, '0);
    send_power(all_ones, '0);
    send_power('0, all_ones);
    send_power(all_ones, all_ones);
    send_power(FieldW'(2), FieldW'(1));
    send_power(FieldW'(1000000007), FieldW'(5));
    send_power(FieldW'(1000000006), FieldW'(3));
    send_power(FieldW'(1000000006), FieldW'(1) << (FieldW - 1));
    send_power(FieldW'(7), FieldW'(1000000006));
    send_power(FieldW'(3), {1'b0, {(FieldW-1){1'b1}}});
    send_power(all_ones, FieldW'(1));
    send_power(FieldW'(1) << (FieldW - 1), FieldW'(2));

    // Each phase sets a new modulus, including the smallest, the largest and
    // the degenerate zero and one, and varies how often the sender idles.
    for (int phase = 0; phase < 7; phase++) begin
      write_modulus(moduli[phase]);
      case (phase % 4)
        1:       sender_idle_pct = 80;
        3:       sender_idle_pct = 20;
        default: sender_idle_pct = 0;
      endcase
      if (phase == 6) write_modulus(ModW'($urandom_range(32'h7FFF_FFFF, 2)));
      for (int n = 0; n < 162; n++) send_power(pick_base(), pick_exponent());
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
+incdir+design
design/modexp_pkg.sv
design/modexp_ctrl.sv
design/modexp_dp.sv
design/modular_exponentiation_top.sv
design/modexp_chk.sv
verif/modular_exponentiation_checker.sv
verif/testbench.sv
